// ===== rtl/mtep_pkg.sv =====
// shared types, codes and helpers for the midi track event parser
package mtep_pkg;

    // saturation limit of a variable-length value
    localparam logic [27:0] MAX28 = 28'hFFFFFFF;
    localparam logic [27:0] VLQ_SAT_LIMIT = 28'h01FFFFF;

    // queue between classifier and parser
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // result kind codes
    localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
    localparam logic [2:0] KIND_TEMPO    = 3'd2;
    localparam logic [2:0] KIND_TIME_SIG = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;
    localparam logic [2:0] KIND_SKIPPED  = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

    // meta type codes
    localparam logic [7:0] META_SET_TEMPO = 8'h51;
    localparam logic [7:0] META_TIME_SIG  = 8'h58;
    localparam logic [7:0] META_END       = 8'h2F;
    localparam logic [7:0] STATUS_META    = 8'hFF;

    // status byte classes
    typedef enum logic [2:0] {
        ST_UNKNOWN,
        ST_NOTE_ON,
        ST_NOTE_OFF,
        ST_SKIP2,
        ST_SKIP1,
        ST_SYSEX,
        ST_META
    } status_class_t;

    // meta type classes
    typedef enum logic [1:0] {
        MC_OTHER,
        MC_TEMPO,
        MC_TIME_SIG,
        MC_END
    } meta_class_t;

    // input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_track;
    } in_t;

    // result request
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [27:0] delta_ticks;
        logic [6:0]  note_number;
        logic [6:0]  note_velocity;
        logic [23:0] tempo_us;
        logic [7:0]  sig_numerator;
        logic [7:0]  sig_denominator_log2;
    } out_t;

    // classified byte as queued for the parser
    typedef struct packed {
        logic [7:0]    data_byte;
        logic          start_of_track;
        logic          more;
        status_class_t status_class;
        meta_class_t   meta_class;
    } token_t;

    // queue head as seen by the parser
    typedef struct packed {
        logic   valid;
        token_t tok;
    } head_t;

    // one step of a saturating variable-length value
    function automatic logic [27:0] vlq_step(logic [27:0] acc, logic [7:0] b);
        logic [27:0] res;
        if (acc > VLQ_SAT_LIMIT)
        begin
            res = MAX28;
        end
        else
        begin
            res = {acc[20:0], b[6:0]};
        end
        return res;
    endfunction

endpackage

// ===== rtl/midi_track_event_parser.sv =====
// midi track event parser: classifier, token queue and grammar parser
// throughput: one byte per cycle while byte_stall is low; the parser takes one
//   queued token each cycle unless a held result is stalled
// path: queue, parser, output register; a stalled output backs up the queue
// reset: rst_n clears the queue, the parser state and the output valid at once
module midi_track_event_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  mtep_pkg::in_t  byte_req,
    output logic           event_valid,
    input  logic           event_stall,
    output mtep_pkg::out_t event_req
);

    mtep_pkg::token_t tok;
    mtep_pkg::head_t  head;
    logic             full;
    logic             pop;

    // classify incoming bytes
    mtep_front u_front (
        .byte_req (byte_req),
        .tok      (tok)
    );

    // decouple classifier from parser
    mtep_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (byte_valid),
        .push_tok (tok),
        .full     (full),
        .pop      (pop),
        .head     (head)
    );

    assign byte_stall = full;

    // parse and hold results
    mtep_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_req   (event_req)
    );

endmodule

// ===== rtl/mtep_front.sv =====
// byte classifier: tags each incoming byte for the parser
module mtep_front (
    input  mtep_pkg::in_t    byte_req,
    output mtep_pkg::token_t tok
);

    mtep_pkg::status_class_t sc;
    mtep_pkg::meta_class_t   mc;

    // status class from the byte alone
    always_comb
    begin
        if (!byte_req.data_byte[7])
        begin
            sc = mtep_pkg::ST_UNKNOWN;
        end
        else if (byte_req.data_byte == mtep_pkg::STATUS_META)
        begin
            sc = mtep_pkg::ST_META;
        end
        else
        begin
            unique case (byte_req.data_byte[6:4])
                3'd0:       sc = mtep_pkg::ST_NOTE_OFF;
                3'd1:       sc = mtep_pkg::ST_NOTE_ON;
                3'd2, 3'd3, 3'd6: sc = mtep_pkg::ST_SKIP2;
                3'd4, 3'd5: sc = mtep_pkg::ST_SKIP1;
                default:    sc = mtep_pkg::ST_SYSEX;
            endcase
        end
    end

    // meta class in case the byte is a meta type
    always_comb
    begin
        if (byte_req.data_byte == mtep_pkg::META_SET_TEMPO)
        begin
            mc = mtep_pkg::MC_TEMPO;
        end
        else if (byte_req.data_byte == mtep_pkg::META_TIME_SIG)
        begin
            mc = mtep_pkg::MC_TIME_SIG;
        end
        else if (byte_req.data_byte == mtep_pkg::META_END)
        begin
            mc = mtep_pkg::MC_END;
        end
        else
        begin
            mc = mtep_pkg::MC_OTHER;
        end
    end

    // pack the token
    always_comb
    begin
        tok.data_byte      = byte_req.data_byte;
        tok.start_of_track = byte_req.start_of_track;
        tok.more           = byte_req.data_byte[7];
        tok.status_class   = sc;
        tok.meta_class     = mc;
    end

endmodule

// ===== rtl/mtep_queue.sv =====
// short token queue between classifier and parser
module mtep_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mtep_pkg::token_t push_tok,
    output logic             full,
    input  logic             pop,
    output mtep_pkg::head_t  head
);

    mtep_pkg::token_t                       mem [mtep_pkg::QUEUE_DEPTH];
    logic [mtep_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg;
    logic [mtep_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg;
    logic [mtep_pkg::QUEUE_CNT_W-1:0]       count_reg;
    logic [mtep_pkg::QUEUE_PTR_W-1:0]       wr_ptr_next;
    logic [mtep_pkg::QUEUE_PTR_W-1:0]       rd_ptr_next;
    logic [mtep_pkg::QUEUE_CNT_W-1:0]       count_next;
    logic                                   do_push;
    logic                                   do_pop;

    // status
    assign full       = (count_reg == mtep_pkg::QUEUE_CNT_W'(mtep_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.tok   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + mtep_pkg::QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + mtep_pkg::QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + mtep_pkg::QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - mtep_pkg::QUEUE_CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ===== rtl/mtep_back.sv =====
// parser: walks the event grammar one token per cycle while the output is not stalled, and registers results
module mtep_back (
    input  logic            clk,
    input  logic            rst_n,
    input  mtep_pkg::head_t head,
    output logic            pop,
    output logic            event_valid,
    input  logic            event_stall,
    output mtep_pkg::out_t  event_req
);

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_NOTE1,
        PH_NOTE2,
        PH_SKIP,
        PH_SYSLEN,
        PH_MTYPE,
        PH_MLEN,
        PH_MBODY
    } phase_t;

    phase_t                phase_reg, phase_next, phase_cur;
    logic [27:0]           vlq_reg, vlq_next, vlq_cur;
    logic [27:0]           held_reg, held_next, held_cur;
    logic                  note_on_reg, note_on_next, note_on_cur;
    logic [7:0]            first_reg, first_next, first_cur;
    mtep_pkg::meta_class_t meta_reg, meta_next, meta_cur;
    logic [27:0]           left_reg, left_next, left_cur;
    logic [23:0]           tempo_reg, tempo_next, tempo_cur;
    logic [1:0]            idx_reg, idx_next, idx_cur;
    logic                  out_valid_reg, out_valid_next;
    mtep_pkg::out_t        out_data_reg, out_data_next;
    mtep_pkg::token_t      tok;
    logic [27:0]           vlq_stepped;
    logic [27:0]           left_dec;
    logic                  emit;
    mtep_pkg::out_t        evt;

    assign tok         = head.tok;
    assign pop         = head.valid && (!out_valid_reg || !event_stall);
    assign event_valid = out_valid_reg;
    assign event_req   = out_data_reg;

    // start of track restarts from the reset state
    always_comb
    begin
        if (tok.start_of_track)
        begin
            phase_cur   = PH_DELTA;
            vlq_cur     = '0;
            held_cur    = '0;
            note_on_cur = 1'b0;
            first_cur   = '0;
            meta_cur    = mtep_pkg::MC_OTHER;
            left_cur    = '0;
            tempo_cur   = '0;
            idx_cur     = '0;
        end
        else
        begin
            phase_cur   = phase_reg;
            vlq_cur     = vlq_reg;
            held_cur    = held_reg;
            note_on_cur = note_on_reg;
            first_cur   = first_reg;
            meta_cur    = meta_reg;
            left_cur    = left_reg;
            tempo_cur   = tempo_reg;
            idx_cur     = idx_reg;
        end
    end

    assign vlq_stepped = mtep_pkg::vlq_step(vlq_cur, tok.data_byte);
    assign left_dec    = (left_cur != '0) ? left_cur - 28'd1 : '0;

    // grammar step
    always_comb
    begin
        phase_next   = phase_cur;
        vlq_next     = vlq_cur;
        held_next    = held_cur;
        note_on_next = note_on_cur;
        first_next   = first_cur;
        meta_next    = meta_cur;
        left_next    = left_cur;
        tempo_next   = tempo_cur;
        idx_next     = idx_cur;
        emit         = 1'b0;
        evt          = '0;

        unique case (phase_cur)
            PH_DELTA:
            begin
                vlq_next = vlq_stepped;
                if (!tok.more)
                begin
                    held_next  = vlq_stepped;
                    vlq_next   = '0;
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                unique case (tok.status_class)
                    mtep_pkg::ST_UNKNOWN:
                    begin
                        emit           = 1'b1;
                        evt.event_kind = mtep_pkg::KIND_UNKNOWN;
                    end
                    mtep_pkg::ST_META:
                    begin
                        phase_next = PH_MTYPE;
                    end
                    mtep_pkg::ST_NOTE_ON, mtep_pkg::ST_NOTE_OFF:
                    begin
                        note_on_next = (tok.status_class == mtep_pkg::ST_NOTE_ON);
                        phase_next   = PH_NOTE1;
                    end
                    mtep_pkg::ST_SKIP2:
                    begin
                        left_next  = 28'd2;
                        phase_next = PH_SKIP;
                    end
                    mtep_pkg::ST_SKIP1:
                    begin
                        left_next  = 28'd1;
                        phase_next = PH_SKIP;
                    end
                    default:
                    begin
                        vlq_next   = '0;
                        phase_next = PH_SYSLEN;
                    end
                endcase
            end
            PH_NOTE1:
            begin
                first_next = tok.data_byte;
                phase_next = PH_NOTE2;
            end
            PH_NOTE2:
            begin
                emit              = 1'b1;
                evt.event_kind    = note_on_cur ? mtep_pkg::KIND_NOTE_ON
                                                : mtep_pkg::KIND_NOTE_OFF;
                evt.note_number   = first_cur[6:0];
                evt.note_velocity = tok.data_byte[6:0];
            end
            PH_SKIP:
            begin
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    emit           = 1'b1;
                    evt.event_kind = mtep_pkg::KIND_SKIPPED;
                end
            end
            PH_SYSLEN:
            begin
                vlq_next = vlq_stepped;
                if (!tok.more)
                begin
                    left_next = vlq_stepped;
                    vlq_next  = '0;
                    if (vlq_stepped == '0)
                    begin
                        emit           = 1'b1;
                        evt.event_kind = mtep_pkg::KIND_SKIPPED;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_MTYPE:
            begin
                meta_next  = tok.meta_class;
                vlq_next   = '0;
                tempo_next = '0;
                idx_next   = '0;
                phase_next = PH_MLEN;
            end
            PH_MLEN:
            begin
                vlq_next = vlq_stepped;
                if (!tok.more)
                begin
                    left_next = vlq_stepped;
                    vlq_next  = '0;
                    if (vlq_stepped == '0)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MBODY;
                    end
                end
            end
            PH_MBODY:
            begin
                unique case (idx_cur)
                    2'd0:    tempo_next = tempo_cur | {tok.data_byte, 16'h0000};
                    2'd1:    tempo_next = tempo_cur | {8'h00, tok.data_byte, 8'h00};
                    2'd2:    tempo_next = tempo_cur | {16'h0000, tok.data_byte};
                    default: tempo_next = tempo_cur;
                endcase
                if (idx_cur != 2'd3)
                begin
                    idx_next = idx_cur + 2'd1;
                end
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                vlq_next   = '0;
                phase_next = PH_DELTA;
            end
        endcase

        // meta results take their kind from the stored type
        if (emit && (phase_cur == PH_MLEN || phase_cur == PH_MBODY))
        begin
            unique case (meta_cur)
                mtep_pkg::MC_TEMPO:
                begin
                    evt.event_kind = mtep_pkg::KIND_TEMPO;
                    evt.tempo_us   = tempo_next;
                end
                mtep_pkg::MC_TIME_SIG:
                begin
                    evt.event_kind           = mtep_pkg::KIND_TIME_SIG;
                    evt.sig_numerator        = tempo_next[23:16];
                    evt.sig_denominator_log2 = tempo_next[15:8];
                end
                mtep_pkg::MC_END:
                begin
                    evt.event_kind = mtep_pkg::KIND_END;
                end
                default:
                begin
                    evt.event_kind = mtep_pkg::KIND_SKIPPED;
                end
            endcase
        end

        // every result closes the event
        evt.delta_ticks = held_next;
        if (emit)
        begin
            phase_next = PH_DELTA;
            vlq_next   = '0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && event_stall;
        out_data_next  = out_data_reg;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = evt;
        end
    end

    // parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DELTA;
            vlq_reg       <= '0;
            held_reg      <= '0;
            note_on_reg   <= 1'b0;
            first_reg     <= '0;
            meta_reg      <= mtep_pkg::MC_OTHER;
            left_reg      <= '0;
            tempo_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg   <= phase_next;
                vlq_reg     <= vlq_next;
                held_reg    <= held_next;
                note_on_reg <= note_on_next;
                first_reg   <= first_next;
                meta_reg    <= meta_next;
                left_reg    <= left_next;
                tempo_reg   <= tempo_next;
                idx_reg     <= idx_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== verif/midi_track_event_parser_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the midi track event parser
module midi_track_event_parser_tb;
    import mtep_pkg::*;

    localparam int     CLK_PERIOD   = 10;
    localparam int     RESET_CYCLES = 7;
    localparam int     RANDOM_ITEMS = 1950;
    localparam int     LONG_HOLD    = 300;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     MAX_REPORTS  = 10;
    localparam longint TIMEOUT_NS   = 5_000_000;

    // status nibbles of channel and system messages
    localparam logic [3:0] STATUS_NOTE_OFF      = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON       = 4'h9;
    localparam logic [3:0] STATUS_POLY_PRESSURE = 4'hA;
    localparam logic [3:0] STATUS_CONTROL       = 4'hB;
    localparam logic [3:0] STATUS_PROGRAM       = 4'hC;
    localparam logic [3:0] STATUS_CHAN_PRESSURE = 4'hD;
    localparam logic [3:0] STATUS_PITCH_BEND    = 4'hE;
    localparam logic [3:0] STATUS_SYSTEM        = 4'hF;

    // grammar position of the parser model
    typedef enum logic [3:0] {
        EXP_DELTA,
        EXP_STATUS,
        EXP_NOTE_KEY,
        EXP_NOTE_VEL,
        EXP_SKIP,
        EXP_SYSEX_LEN,
        EXP_META_TYPE,
        EXP_META_LEN,
        EXP_META_BODY
    } parse_phase_t;

    // stall patterns of the result side
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_LIGHT,
        SINK_PERIODIC,
        SINK_HEAVY
    } sink_mode_t;

    // one byte to send, with an optional hand-written expected event
    typedef struct {
        in_t  req;
        bit   typed;
        out_t ev;
    } track_byte_t;

    logic clk = 1'b0;
    logic rst_n;
    logic byte_valid;
    logic byte_stall;
    in_t  byte_req;
    logic event_valid;
    logic event_stall;
    out_t event_req;

    track_byte_t track_bytes[$];
    out_t        expected_events[$];
    int          bytes_taken  = 0;
    int          error_count  = 0;
    int          report_count = 0;
    bit          long_hold_req = 1'b0;

    // parser model state
    parse_phase_t phase_q;
    logic [27:0]  vlq_acc;
    logic [27:0]  event_delta;
    logic [27:0]  remaining;
    logic [7:0]   status_held;
    logic [7:0]   key_held;
    logic [7:0]   meta_code;
    logic [23:0]  body_word;
    logic [1:0]   body_count;

    midi_track_event_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_req    (byte_req),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_req   (event_req)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // parser model
    function automatic void clear_parser_model();
        phase_q     = EXP_DELTA;
        vlq_acc     = '0;
        event_delta = '0;
        remaining   = '0;
        status_held = '0;
        key_held    = '0;
        meta_code   = '0;
        body_word   = '0;
        body_count  = '0;
    endfunction

    function automatic logic [27:0] vlq_accumulate(logic [27:0] acc, logic [7:0] b);
        logic [27:0] res;
        if (acc > (MAX28 >> 7))
        begin
            res = MAX28;
        end
        else
        begin
            res = {acc[20:0], b[6:0]};
        end
        return res;
    endfunction

    function automatic out_t event_of(logic [2:0] kind, logic [27:0] delta,
                                      logic [6:0] note, logic [6:0] vel,
                                      logic [23:0] tempo, logic [7:0] num,
                                      logic [7:0] den);
        out_t ev;
        ev.event_kind           = kind;
        ev.delta_ticks          = delta;
        ev.note_number          = note;
        ev.note_velocity        = vel;
        ev.tempo_us             = tempo;
        ev.sig_numerator        = num;
        ev.sig_denominator_log2 = den;
        return ev;
    endfunction

    // event closes: back to a fresh delta time
    function automatic out_t finish_event(logic [2:0] kind, logic [6:0] note,
                                          logic [6:0] vel, logic [23:0] tempo,
                                          logic [7:0] num, logic [7:0] den);
        phase_q = EXP_DELTA;
        vlq_acc = '0;
        return event_of(kind, event_delta, note, vel, tempo, num, den);
    endfunction

    function automatic out_t finish_meta();
        out_t ev;
        if (meta_code == META_SET_TEMPO)
        begin
            ev = finish_event(KIND_TEMPO, '0, '0, body_word, '0, '0);
        end
        else if (meta_code == META_TIME_SIG)
        begin
            ev = finish_event(KIND_TIME_SIG, '0, '0, '0, body_word[23:16], body_word[15:8]);
        end
        else if (meta_code == META_END)
        begin
            ev = finish_event(KIND_END, '0, '0, '0, '0, '0);
        end
        else
        begin
            ev = finish_event(KIND_SKIPPED, '0, '0, '0, '0, '0);
        end
        return ev;
    endfunction

    function automatic bit predict_event(in_t req, output out_t ev);
        logic [7:0] b;
        bit         fired;
        b     = req.data_byte;
        fired = 1'b0;
        ev    = '0;
        if (req.start_of_track)
        begin
            clear_parser_model();
        end
        case (phase_q)
            EXP_DELTA:
            begin
                vlq_acc = vlq_accumulate(vlq_acc, b);
                if (!b[7])
                begin
                    event_delta = vlq_acc;
                    vlq_acc     = '0;
                    phase_q     = EXP_STATUS;
                end
            end
            EXP_STATUS:
            begin
                status_held = b;
                if (!b[7])
                begin
                    ev    = finish_event(KIND_UNKNOWN, '0, '0, '0, '0, '0);
                    fired = 1'b1;
                end
                else if (b == STATUS_META)
                begin
                    phase_q = EXP_META_TYPE;
                end
                else
                begin
                    case (b[7:4])
                        STATUS_NOTE_OFF, STATUS_NOTE_ON:
                        begin
                            phase_q = EXP_NOTE_KEY;
                        end
                        STATUS_POLY_PRESSURE, STATUS_CONTROL, STATUS_PITCH_BEND:
                        begin
                            remaining = 28'd2;
                            phase_q   = EXP_SKIP;
                        end
                        STATUS_PROGRAM, STATUS_CHAN_PRESSURE:
                        begin
                            remaining = 28'd1;
                            phase_q   = EXP_SKIP;
                        end
                        default:
                        begin
                            vlq_acc = '0;
                            phase_q = EXP_SYSEX_LEN;
                        end
                    endcase
                end
            end
            EXP_NOTE_KEY:
            begin
                key_held = b;
                phase_q  = EXP_NOTE_VEL;
            end
            EXP_NOTE_VEL:
            begin
                ev = finish_event((status_held[7:4] == STATUS_NOTE_ON) ? KIND_NOTE_ON
                                                                       : KIND_NOTE_OFF,
                                  key_held[6:0], b[6:0], '0, '0, '0);
                fired = 1'b1;
            end
            EXP_SKIP:
            begin
                if (remaining != '0)
                begin
                    remaining = remaining - 28'd1;
                end
                if (remaining == '0)
                begin
                    ev    = finish_event(KIND_SKIPPED, '0, '0, '0, '0, '0);
                    fired = 1'b1;
                end
            end
            EXP_SYSEX_LEN:
            begin
                vlq_acc = vlq_accumulate(vlq_acc, b);
                if (!b[7])
                begin
                    remaining = vlq_acc;
                    vlq_acc   = '0;
                    if (remaining == '0)
                    begin
                        ev    = finish_event(KIND_SKIPPED, '0, '0, '0, '0, '0);
                        fired = 1'b1;
                    end
                    else
                    begin
                        phase_q = EXP_SKIP;
                    end
                end
            end
            EXP_META_TYPE:
            begin
                meta_code  = b;
                vlq_acc    = '0;
                body_word  = '0;
                body_count = '0;
                phase_q    = EXP_META_LEN;
            end
            EXP_META_LEN:
            begin
                vlq_acc = vlq_accumulate(vlq_acc, b);
                if (!b[7])
                begin
                    remaining = vlq_acc;
                    vlq_acc   = '0;
                    if (remaining == '0)
                    begin
                        ev    = finish_meta();
                        fired = 1'b1;
                    end
                    else
                    begin
                        phase_q = EXP_META_BODY;
                    end
                end
            end
            EXP_META_BODY:
            begin
                // first three body bytes fill the value, msb first
                if (body_count < 2'd3)
                begin
                    case (body_count)
                        2'd0:    body_word[23:16] = body_word[23:16] | b;
                        2'd1:    body_word[15:8]  = body_word[15:8] | b;
                        default: body_word[7:0]   = body_word[7:0] | b;
                    endcase
                    body_count = body_count + 2'd1;
                end
                if (remaining != '0)
                begin
                    remaining = remaining - 28'd1;
                end
                if (remaining == '0)
                begin
                    ev    = finish_meta();
                    fired = 1'b1;
                end
            end
            default:
            begin
                phase_q = EXP_DELTA;
                vlq_acc = '0;
            end
        endcase
        return fired;
    endfunction

    // track byte planning
    task automatic plan_byte(logic [7:0] b, logic sot);
        track_byte_t row;
        row.req.data_byte      = b;
        row.req.start_of_track = sot;
        row.typed              = 1'b0;
        row.ev                 = '0;
        track_bytes.push_back(row);
    endtask

    task automatic plan_checked(logic [7:0] b, logic sot, out_t ev);
        track_byte_t row;
        row.req.data_byte      = b;
        row.req.start_of_track = sot;
        row.typed              = 1'b1;
        row.ev                 = ev;
        track_bytes.push_back(row);
    endtask

    // well-formed delta time of one to seven bytes, now and then restarting the track
    task automatic plan_delta();
        int         n;
        int         pick;
        bit         sot;
        logic [6:0] group;
        pick = $urandom_range(0, 99);
        sot  = ($urandom_range(0, 9) == 0);
        if (pick < 50)
        begin
            n = 1;
        end
        else if (pick < 75)
        begin
            n = 2;
        end
        else if (pick < 90)
        begin
            n = $urandom_range(3, 4);
        end
        else
        begin
            n = $urandom_range(5, 7);
        end
        for (int k = 0; k < n; k++)
        begin
            group = (pick >= 95) ? 7'h7F : 7'($urandom);
            plan_byte({(k != n - 1), group}, (k == 0) && sot);
        end
    endtask

    // body length: mostly short, sometimes the usual size, rarely past one group
    function automatic int body_length(int usual);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3)
        begin
            return 128 + $urandom_range(0, 16);
        end
        if (sel < 60 && usual >= 0)
        begin
            return usual;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic plan_length(int len);
        if (len >= 128)
        begin
            plan_byte({1'b1, 7'(len >> 7)}, 1'b0);
            plan_byte({1'b0, 7'(len)}, 1'b0);
        end
        else if ($urandom_range(0, 6) == 0)
        begin
            // redundant leading zero group
            plan_byte(8'h80, 1'b0);
            plan_byte({1'b0, 7'(len)}, 1'b0);
        end
        else
        begin
            plan_byte({1'b0, 7'(len)}, 1'b0);
        end
    endtask

    task automatic plan_event();
        int         pick;
        int         sel;
        int         len;
        logic [3:0] nibble;
        logic [7:0] code;
        pick = $urandom_range(0, 99);
        // noise: loose bytes, some restarting the track mid-event
        if (pick >= 96)
        begin
            repeat ($urandom_range(1, 4)) plan_byte(8'($urandom), ($urandom_range(0, 3) == 0));
            return;
        end
        plan_delta();
        if (pick < 40)
        begin
            nibble = (pick < 25) ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
            plan_byte({nibble, 4'($urandom)}, 1'b0);
            plan_byte(8'($urandom), 1'b0);
            plan_byte(8'($urandom), 1'b0);
        end
        else if (pick < 50)
        begin
            sel    = $urandom_range(0, 2);
            nibble = (sel == 0) ? STATUS_POLY_PRESSURE
                   : (sel == 1) ? STATUS_CONTROL : STATUS_PITCH_BEND;
            plan_byte({nibble, 4'($urandom)}, 1'b0);
            plan_byte(8'($urandom), 1'b0);
            plan_byte(8'($urandom), 1'b0);
        end
        else if (pick < 58)
        begin
            nibble = $urandom_range(0, 1) ? STATUS_PROGRAM : STATUS_CHAN_PRESSURE;
            plan_byte({nibble, 4'($urandom)}, 1'b0);
            plan_byte(8'($urandom), 1'b0);
        end
        else if (pick < 66)
        begin
            plan_byte({STATUS_SYSTEM, 4'($urandom_range(0, 14))}, 1'b0);
            len = body_length(-1);
            plan_length(len);
            repeat (len) plan_byte(8'($urandom), 1'b0);
        end
        else if (pick < 91)
        begin
            plan_byte(STATUS_META, 1'b0);
            sel = $urandom_range(0, 99);
            if (sel < 35)
            begin
                code = META_SET_TEMPO;
                len  = body_length(3);
            end
            else if (sel < 65)
            begin
                code = META_TIME_SIG;
                len  = body_length(4);
            end
            else if (sel < 80)
            begin
                code = META_END;
                len  = body_length(0);
            end
            else
            begin
                code = 8'($urandom);
                len  = body_length(-1);
            end
            plan_byte(code, 1'b0);
            plan_length(len);
            repeat (len) plan_byte(8'($urandom), 1'b0);
        end
        else
        begin
            plan_byte({1'b0, 7'($urandom)}, 1'b0);
        end
    endtask

    // scoreboard: results against expectations, then predict from accepted bytes
    always @(posedge clk)
    begin : scoreboard
        out_t want;
        out_t predicted;
        bit   fired;
        if (rst_n)
        begin
            // check a result request
            if (event_valid && !event_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    error_count++;
                    if (report_count < MAX_REPORTS)
                    begin
                        report_count++;
                        $display("unexpected event at %0t: kind %0d delta %0d",
                                 $time, event_req.event_kind, event_req.delta_ticks);
                    end
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_req.event_kind !== want.event_kind
                        || event_req.delta_ticks !== want.delta_ticks
                        || event_req.note_number !== want.note_number
                        || event_req.note_velocity !== want.note_velocity
                        || event_req.tempo_us !== want.tempo_us
                        || event_req.sig_numerator !== want.sig_numerator
                        || event_req.sig_denominator_log2 !== want.sig_denominator_log2)
                    begin
                        error_count++;
                        if (report_count < MAX_REPORTS)
                        begin
                            report_count++;
                            $display("event mismatch at %0t", $time);
                            $display("  expected kind %0d delta %0d note %0d vel %0d",
                                     want.event_kind, want.delta_ticks, want.note_number,
                                     want.note_velocity);
                            $display("           tempo %0d num %0d den %0d",
                                     want.tempo_us, want.sig_numerator,
                                     want.sig_denominator_log2);
                            $display("  actual   kind %0d delta %0d note %0d vel %0d",
                                     event_req.event_kind, event_req.delta_ticks,
                                     event_req.note_number, event_req.note_velocity);
                            $display("           tempo %0d num %0d den %0d",
                                     event_req.tempo_us, event_req.sig_numerator,
                                     event_req.sig_denominator_log2);
                        end
                    end
                end
            end
            // predict from an input request
            if (byte_valid && !byte_stall)
            begin
                fired = predict_event(byte_req, predicted);
                if (track_bytes[bytes_taken].typed)
                begin
                    expected_events.push_back(track_bytes[bytes_taken].ev);
                end
                else if (fired)
                begin
                    expected_events.push_back(predicted);
                end
                bytes_taken++;
            end
        end
    end

    // byte sender: bursts with random gaps
    initial
    begin : byte_source
        int random_start;
        int hold_at;
        int pause_at;
        int burst_left;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_req   = '0;
        clear_parser_model();

        // directed table: extremes, saturation, unknown status, empty bodies
        plan_byte(8'h00, 1'b1);
        plan_byte({STATUS_NOTE_ON, 4'h0}, 1'b0);
        plan_byte(8'hFF, 1'b0);
        plan_checked(8'hFF, 1'b0, event_of(KIND_NOTE_ON, 28'd0, 7'd127, 7'd127, '0, '0, '0));
        plan_byte(8'h00, 1'b0);
        plan_checked(8'h7F, 1'b0, event_of(KIND_UNKNOWN, 28'd0, '0, '0, '0, '0, '0));
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'h7F, 1'b0);
        plan_byte(STATUS_META, 1'b0);
        plan_byte(META_END, 1'b0);
        plan_checked(8'h00, 1'b0, event_of(KIND_END, MAX28, '0, '0, '0, '0, '0));
        plan_byte(8'h00, 1'b0);
        plan_byte(STATUS_META, 1'b0);
        plan_byte(META_SET_TEMPO, 1'b0);
        plan_byte(8'h03, 1'b0);
        plan_byte(8'h07, 1'b0);
        plan_byte(8'hA1, 1'b0);
        plan_byte(8'h20, 1'b0);
        plan_byte(8'h00, 1'b0);
        plan_byte({STATUS_NOTE_OFF, 4'hF}, 1'b0);
        plan_byte(8'h00, 1'b0);
        plan_checked(8'h00, 1'b0, event_of(KIND_NOTE_OFF, 28'd0, '0, '0, '0, '0, '0));
        plan_byte(8'h00, 1'b0);
        plan_byte({STATUS_SYSTEM, 4'h0}, 1'b0);
        plan_checked(8'h00, 1'b0, event_of(KIND_SKIPPED, 28'd0, '0, '0, '0, '0, '0));

        // random track content
        random_start = track_bytes.size();
        while (track_bytes.size() < random_start + RANDOM_ITEMS)
        begin
            plan_event();
        end

        // sysex with a saturated length, then a restart of the track
        plan_byte(8'h00, 1'b0);
        plan_byte({STATUS_SYSTEM, 4'h0}, 1'b0);
        repeat (4) plan_byte(8'hFF, 1'b0);
        plan_byte(8'h7F, 1'b0);
        repeat (6) plan_byte(8'($urandom), 1'b0);
        plan_byte(8'h00, 1'b1);
        plan_byte({STATUS_NOTE_ON, 4'($urandom)}, 1'b0);
        plan_byte(8'($urandom), 1'b0);
        plan_byte(8'($urandom), 1'b0);

        hold_at  = random_start + 500;
        pause_at = random_start + 1100;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        burst_left = 0;
        for (int i = 0; i < track_bytes.size(); i++)
        begin
            if (i == hold_at)
            begin
                long_hold_req = 1'b1;
            end
            // let everything drain before going on
            if (i == pause_at)
            begin
                @(negedge clk);
                byte_valid <= 1'b0;
                while (expected_events.size() != 0) @(negedge clk);
            end
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        @(negedge clk);
                        byte_valid <= 1'b0;
                    end
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            @(negedge clk);
            byte_valid <= 1'b1;
            byte_req   <= track_bytes[i].req;
            @(posedge clk);
            while (!(byte_valid && !byte_stall)) @(posedge clk);
        end
        @(negedge clk);
        byte_valid <= 1'b0;

        // wait for the last results, then idle before finishing
        while (expected_events.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // result receiver: changing stall patterns and one long hold-off
    initial
    begin : result_sink
        int         hold_left;
        int         mode_left;
        int         tick;
        sink_mode_t mode;
        event_stall = 1'b0;
        hold_left   = 0;
        mode_left   = 0;
        tick        = 0;
        mode        = SINK_OPEN;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                event_stall <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                event_stall  <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:     event_stall <= 1'b0;
                    SINK_LIGHT:    event_stall <= ($urandom_range(0, 99) < 30);
                    SINK_PERIODIC: event_stall <= ((tick % 4) == 3);
                    default:       event_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
